// ===== sv/rdcs_pkg.sv =====
// ============================================================================
// rdcs_pkg
// Shared types and constants for the revolving-door combination stepper.
// ============================================================================
package rdcs_pkg;

    localparam int MAX_K = 32;

    localparam int IDX_W  = 16;
    localparam int KCFG_W = 6;
    localparam int CFG_W  = 16;

    localparam logic [KCFG_W-1:0] SUBSET_SIZE_RST = 6'd1;
    localparam logic [IDX_W-1:0]  SET_SIZE_RST    = 16'd2;

    // Configuration register indexes.
    localparam logic REG_SUBSET_SIZE = 1'b0;
    localparam logic REG_SET_SIZE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WALK,
        ST_WRITE2,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill;
        logic eval;
        logic write2;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic restart_req;
        logic restart_ok;
        logic exhausted;
        logic fill_last;
        logic hit;
        logic two_writes;
        logic walk_end;
        logic out_free;
    } status_t;

endpackage

// ===== sv/revolving_door_combination_step.sv =====
// Sequence: accept, then walk positions until one moves (up to k), then a
// second memory write for a two-entry update, then push the result. A restart
// writes one memory entry per index plus a sentinel; finished or invalid items
// go from accept to push. A new request is taken only after the last push.
// Reset is asynchronous, active low: walk finished, k = 1, n = 2, memory uncleared.
// ============================================================================
// revolving_door_combination_step
// Steps through k-subsets of {0..n-1} in revolving-door order, one swap per
// request, reporting the element removed and the element added; a restart request reloads the first subset.
// ============================================================================
module revolving_door_combination_step #(
    parameter int MaxK = rdcs_pkg::MAX_K
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [15:0] removed_index, [31:16] added_index
    output logic                          m_tuser,   // [0] finished
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [rdcs_pkg::CFG_W-1:0]    cfg_wdata
);

    rdcs_pkg::cmd_t    cmd;
    rdcs_pkg::status_t status;

    rdcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rdcs_dp #(
        .MaxK (MaxK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/rdcs_dp.sv =====
// ============================================================================
// rdcs_dp
// Datapath: index memory, position walker, configuration and result registers.
// ============================================================================
module rdcs_dp #(
    parameter int MaxK = rdcs_pkg::MAX_K
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [15:0] removed_index, [31:16] added_index
    output logic                          m_tuser,   // [0] finished
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [rdcs_pkg::CFG_W-1:0]    cfg_wdata,
    input  rdcs_pkg::cmd_t                cmd,
    output rdcs_pkg::status_t             status
);

    localparam int AddrW = $clog2(MaxK + 1);
    localparam int Depth = MaxK + 1;
    localparam int IdxW  = rdcs_pkg::IDX_W;

    logic [IdxW-1:0] mem [Depth];

    logic [rdcs_pkg::KCFG_W-1:0] subset_size_reg;
    logic [IdxW-1:0]             set_size_reg;
    logic [AddrW-1:0]            k_walk_reg, k_walk_next;
    logic                        exhausted_reg, exhausted_next;
    logic [AddrW-1:0]            j_reg, j_next;
    logic [IdxW-1:0]             prev_reg;
    logic [IdxW-1:0]             rd_a_reg, rd_b_reg;
    logic [AddrW-1:0]            w2_addr_reg;
    logic [IdxW-1:0]             w2_data_reg;
    logic [IdxW-1:0]             pend_rem_reg, pend_rem_next;
    logic [IdxW-1:0]             pend_add_reg, pend_add_next;
    logic                        pend_fin_reg, pend_fin_next;
    logic                        m_tvalid_reg;
    logic [31:0]                 m_tdata_reg;
    logic                        m_tuser_reg;

    logic                 in_restart;
    logic                 restart_ok;
    logic                 fill_last;
    logic                 inc_mode;
    logic                 first_pos;
    logic                 hit;
    logic                 walk_end;
    logic [IdxW:0]        rd_a_p1;
    logic [IdxW-1:0]      j_idx;
    logic [AddrW-1:0]     j_m1;
    logic [AddrW:0]       j_p2;
    logic [IdxW-1:0]      step_rem, step_add;
    logic                 we;
    logic [AddrW-1:0]     wa;
    logic [IdxW-1:0]      wd;
    logic [AddrW-1:0]     w2a;
    logic [IdxW-1:0]      w2d;
    logic                 rd_en;
    logic [AddrW-1:0]     ra, rb;
    logic                 out_free;

    assign in_restart = s_tdata[0];
    assign restart_ok = (subset_size_reg != '0)
                     && (32'(subset_size_reg) <= MaxK)
                     && (IdxW'(subset_size_reg) <= set_size_reg);
    assign fill_last  = (j_reg == k_walk_reg);

    // Position j increases when j + k is odd and decreases otherwise.
    assign inc_mode  = j_reg[0] ^ k_walk_reg[0];
    assign first_pos = (j_reg == '0);
    assign rd_a_p1   = (IdxW+1)'(rd_a_reg) + (IdxW+1)'(1);
    assign hit       = inc_mode ? (rd_a_p1 < {1'b0, rd_b_reg})
                                : (32'(rd_a_reg) > 32'(j_reg));
    assign walk_end  = (32'(j_reg) + 32'd1) >= 32'(k_walk_reg);
    assign j_idx     = IdxW'(j_reg);
    assign j_m1      = j_reg - AddrW'(1);
    assign j_p2      = (AddrW+1)'(j_reg) + (AddrW+1)'(2);

    always_comb
    begin
        if (inc_mode)
        begin
            step_rem = first_pos ? rd_a_reg : prev_reg;
            step_add = rd_a_p1[IdxW-1:0];
        end
        else
        begin
            step_rem = rd_a_reg;
            step_add = first_pos ? (rd_a_reg - IdxW'(1)) : (j_idx - IdxW'(1));
        end
    end

    // Single write port: the walk's first write goes out in the evaluate
    // cycle, the second one is held for the following cycle.
    always_comb
    begin
        we  = 1'b0;
        wa  = '0;
        wd  = '0;
        w2a = inc_mode ? j_reg : j_m1;
        w2d = inc_mode ? rd_a_p1[IdxW-1:0] : (j_idx - IdxW'(1));
        if (cmd.fill)
        begin
            we = 1'b1;
            wa = j_reg;
            wd = fill_last ? set_size_reg : j_idx;
        end
        else if (cmd.eval && hit)
        begin
            we = 1'b1;
            if (first_pos)
            begin
                wa = '0;
                wd = step_add;
            end
            else if (inc_mode)
            begin
                wa = j_m1;
                wd = rd_a_reg;
            end
            else
            begin
                wa = j_reg;
                wd = prev_reg;
            end
        end
        else if (cmd.write2)
        begin
            we = 1'b1;
            wa = w2_addr_reg;
            wd = w2_data_reg;
        end
    end

    // Reads run one position ahead so that every cycle evaluates a position.
    assign rd_en = (cmd.accept && !in_restart) || cmd.eval;
    assign ra    = cmd.eval ? (j_reg + AddrW'(1)) : AddrW'(0);
    assign rb    = !cmd.eval ? AddrW'(1)
                 : (j_p2 > (AddrW+1)'(MaxK)) ? AddrW'(MaxK) : j_p2[AddrW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
    end

    always_comb
    begin
        k_walk_next    = k_walk_reg;
        exhausted_next = exhausted_reg;
        j_next         = j_reg;
        pend_rem_next  = pend_rem_reg;
        pend_add_next  = pend_add_reg;
        pend_fin_next  = pend_fin_reg;
        if (cmd.accept)
        begin
            j_next        = '0;
            pend_rem_next = '0;
            pend_add_next = '0;
            pend_fin_next = 1'b1;
            if (in_restart)
            begin
                if (restart_ok)
                begin
                    k_walk_next    = AddrW'(subset_size_reg);
                    exhausted_next = 1'b0;
                end
                else
                begin
                    k_walk_next    = '0;
                    exhausted_next = 1'b1;
                end
            end
        end
        else if (cmd.fill)
        begin
            j_next        = j_reg + AddrW'(1);
            pend_fin_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            if (hit)
            begin
                pend_rem_next = step_rem;
                pend_add_next = step_add;
                pend_fin_next = 1'b0;
            end
            else
            begin
                j_next = j_reg + AddrW'(1);
                if (walk_end)
                begin
                    exhausted_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subset_size_reg <= rdcs_pkg::SUBSET_SIZE_RST;
            set_size_reg    <= rdcs_pkg::SET_SIZE_RST;
            k_walk_reg      <= '0;
            exhausted_reg   <= 1'b1;
            j_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    rdcs_pkg::REG_SUBSET_SIZE: subset_size_reg <= cfg_wdata[rdcs_pkg::KCFG_W-1:0];
                    rdcs_pkg::REG_SET_SIZE:    set_size_reg    <= cfg_wdata[IdxW-1:0];
                    default:                   set_size_reg    <= set_size_reg;
                endcase
            end
            k_walk_reg    <= k_walk_next;
            exhausted_reg <= exhausted_next;
            j_reg         <= j_next;
            if (cmd.push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rem_reg <= pend_rem_next;
        pend_add_reg <= pend_add_next;
        pend_fin_reg <= pend_fin_next;
        if (cmd.eval && !hit)
        begin
            prev_reg <= rd_a_reg;
        end
        if (cmd.eval)
        begin
            w2_addr_reg <= w2a;
            w2_data_reg <= w2d;
        end
        if (cmd.push)
        begin
            m_tdata_reg <= {pend_add_reg, pend_rem_reg};
            m_tuser_reg <= pend_fin_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        status.restart_req = in_restart;
        status.restart_ok  = restart_ok;
        status.exhausted   = exhausted_reg;
        status.fill_last   = fill_last;
        status.hit         = hit;
        status.two_writes  = !first_pos;
        status.walk_end    = walk_end;
        status.out_free    = out_free;
    end

    a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (32'(j_reg) < 32'(k_walk_reg)))
        else $error("walk position reached the subset size");

    a_eval_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> !exhausted_reg)
        else $error("walk evaluated on a finished walk");

    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("finished result carries nonzero indices");

endmodule

// ===== sv/rdcs_ctrl.sv =====
// ============================================================================
// rdcs_ctrl
// Controller: sequences accept, fill, walk, second write and result push.
// ============================================================================
module rdcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rdcs_pkg::status_t    status,
    output rdcs_pkg::cmd_t       cmd
);

    rdcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdcs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.restart_req)
                    begin
                        state_next = status.restart_ok ? rdcs_pkg::ST_FILL : rdcs_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = status.exhausted ? rdcs_pkg::ST_PUSH : rdcs_pkg::ST_WALK;
                    end
                end
            end
            rdcs_pkg::ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = rdcs_pkg::ST_PUSH;
                end
            end
            rdcs_pkg::ST_WALK:
            begin
                if (status.hit)
                begin
                    state_next = status.two_writes ? rdcs_pkg::ST_WRITE2 : rdcs_pkg::ST_PUSH;
                end
                else if (status.walk_end)
                begin
                    state_next = rdcs_pkg::ST_PUSH;
                end
            end
            rdcs_pkg::ST_WRITE2:
            begin
                state_next = rdcs_pkg::ST_PUSH;
            end
            rdcs_pkg::ST_PUSH:
            begin
                if (status.out_free)
                begin
                    state_next = rdcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            rdcs_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            rdcs_pkg::ST_FILL:   cmd.fill   = 1'b1;
            rdcs_pkg::ST_WALK:   cmd.eval   = 1'b1;
            rdcs_pkg::ST_WRITE2: cmd.write2 = 1'b1;
            rdcs_pkg::ST_PUSH:   cmd.push   = status.out_free;
            default:             cmd        = '0;
        endcase
    end

    a_write2_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdcs_pkg::ST_WRITE2) |-> ($past(state_reg) == rdcs_pkg::ST_WALK))
        else $error("second write without a preceding walk hit");

    a_push_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdcs_pkg::ST_PUSH && status.out_free)
            |=> (state_reg == rdcs_pkg::ST_IDLE))
        else $error("pushed result did not return to idle");

    a_fill_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdcs_pkg::ST_FILL) |-> !status.exhausted)
        else $error("fill running on an exhausted walk");

endmodule
